// ===== sv/axis_angle_point_rotation_defines.svh =====
// ----------------------------------------------------------------------------
// Axis-angle point rotation: assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_POINT_ROTATION_DEFINES_SVH
`define AXIS_ANGLE_POINT_ROTATION_DEFINES_SVH

// Check on every clock edge outside reset.
`define AAPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define AAPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/aapr_pkg.sv =====
// ----------------------------------------------------------------------------
// Axis-angle point rotation package
// Widths, register indexes, pipeline control and the Q30 clamp helper.
// ----------------------------------------------------------------------------
package aapr_pkg;

    localparam int NUM_AXES   = 3;
    localparam int STAGES     = 7;

    localparam int COORD_W    = 24;
    localparam int OFFSET_W   = 25;
    localparam int Q15_W      = 16;
    localparam int OMC_W      = 17;
    localparam int OUT_W      = 25;
    localparam int ENTRY_W    = 16;
    localparam int AA_W       = 32;
    localparam int PROD_W     = 34;
    localparam int SUM_W      = 35;
    localparam int MP_W       = 41;
    localparam int DOT_W      = 43;
    localparam int WIDE_W     = 44;
    localparam int FRAC_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic signed [OMC_W-1:0]  Q15_ONE         = 17'sh07FFF;
    localparam logic signed [WIDE_W-1:0] Q30_POS_LIMIT   = 44'sh0_4000_0000;
    localparam logic signed [WIDE_W-1:0] Q30_NEG_LIMIT   = -44'sh0_4000_0000;
    localparam logic signed [WIDE_W-1:0] Q30_POS_SAT     = 44'sh0_3FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] Q30_NEG_SAT     = -44'sh0_3FFF_0000;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [OFFSET_W-1:0] offset_t;
    typedef logic signed [Q15_W-1:0]    q15_t;
    typedef logic signed [OMC_W-1:0]    omc_t;
    typedef logic signed [ENTRY_W-1:0]  entry_t;
    typedef logic signed [OUT_W-1:0]    out_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROTATION_ENABLE,
        REG_AXIS_X,
        REG_AXIS_Y,
        REG_AXIS_Z,
        REG_PIVOT_X,
        REG_PIVOT_Y,
        REG_PIVOT_Z
    } cfg_index_t;

    typedef struct packed {
        logic [STAGES-1:0] load;
        logic              rotate;
    } pipe_ctl_t;

    // Saturate to the asymmetric Q30 range, then floor-shift back to Q15.
    function automatic entry_t q30_clamp_shift(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        if (v >= Q30_POS_LIMIT)
        begin
            c = Q30_POS_SAT;
        end
        else if (v <= Q30_NEG_LIMIT)
        begin
            c = Q30_NEG_SAT;
        end
        else
        begin
            c = v;
        end
        return entry_t'(c[FRAC_W+ENTRY_W-1:FRAC_W]);
    endfunction

endpackage

// ===== sv/aapr_lane.sv =====
// ----------------------------------------------------------------------------
// Axis-angle point rotation: row lane
// Builds one row of the Rodrigues matrix and its dot product with the offset.
// ----------------------------------------------------------------------------
module aapr_lane #(
    parameter int ROW = 0
) (
    input  logic                clk,
    input  aapr_pkg::pipe_ctl_t ctl,
    input  aapr_pkg::q15_t      axis [aapr_pkg::NUM_AXES],
    input  aapr_pkg::q15_t      cosine,
    input  aapr_pkg::q15_t      sine,
    input  aapr_pkg::omc_t      omc,
    input  aapr_pkg::offset_t   offset [aapr_pkg::NUM_AXES],
    output aapr_pkg::entry_t    row_result
);

    localparam int NA  = aapr_pkg::NUM_AXES;
    localparam int NXT = (ROW + 1) % NA;
    localparam int PRV = (ROW + 2) % NA;

    // stage 1: axis products and sine cross products
    logic signed [aapr_pkg::AA_W-1:0]   aa_reg [NA];
    logic signed [aapr_pkg::AA_W-1:0]   aa_next [NA];
    logic signed [aapr_pkg::AA_W-1:0]   sa_neg_reg, sa_neg_next;
    logic signed [aapr_pkg::AA_W-1:0]   sa_pos_reg, sa_pos_next;
    aapr_pkg::omc_t                     omc_reg;
    aapr_pkg::q15_t                     cos_reg;
    aapr_pkg::offset_t                  p1_reg [NA];
    // stage 2: (1 - cos) scaling and the diagonal / cross terms
    logic signed [aapr_pkg::PROD_W-1:0] prod_reg [NA];
    logic signed [aapr_pkg::PROD_W-1:0] prod_next [NA];
    logic signed [aapr_pkg::PROD_W-1:0] extra_reg [NA];
    logic signed [aapr_pkg::PROD_W-1:0] extra_next [NA];
    aapr_pkg::offset_t                  p2_reg [NA];
    // stage 3: clamped matrix entries
    aapr_pkg::entry_t                   m_reg [NA];
    aapr_pkg::entry_t                   m_next [NA];
    logic signed [aapr_pkg::SUM_W-1:0]  entry_sum [NA];
    aapr_pkg::offset_t                  p3_reg [NA];
    // stage 4: entry times offset
    logic signed [aapr_pkg::MP_W-1:0]   mp_reg [NA];
    logic signed [aapr_pkg::MP_W-1:0]   mp_next [NA];
    // stage 5: dot product, clamped
    logic signed [aapr_pkg::DOT_W-1:0]  dot;
    aapr_pkg::entry_t                   r_reg, r_next;

    always_comb
    begin
        for (int j = 0; j < NA; j++)
        begin
            aa_next[j] = aapr_pkg::AA_W'(axis[ROW]) * aapr_pkg::AA_W'(axis[j]);
        end
        sa_neg_next = aapr_pkg::AA_W'(sine) * aapr_pkg::AA_W'(axis[PRV]);
        sa_pos_next = aapr_pkg::AA_W'(sine) * aapr_pkg::AA_W'(axis[NXT]);
    end

    always_comb
    begin
        for (int j = 0; j < NA; j++)
        begin
            prod_next[j] = aapr_pkg::PROD_W'(omc_reg)
                * aapr_pkg::PROD_W'($signed(aa_reg[j][aapr_pkg::AA_W-1:aapr_pkg::FRAC_W]));
            if (j == ROW)
            begin
                extra_next[j] = $signed({{(aapr_pkg::PROD_W - aapr_pkg::Q15_W
                                          - aapr_pkg::FRAC_W){cos_reg[aapr_pkg::Q15_W-1]}},
                                         cos_reg, {aapr_pkg::FRAC_W{1'b0}}});
            end
            else if (j == NXT)
            begin
                extra_next[j] = -aapr_pkg::PROD_W'(sa_neg_reg);
            end
            else
            begin
                extra_next[j] = aapr_pkg::PROD_W'(sa_pos_reg);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < NA; j++)
        begin
            entry_sum[j] = aapr_pkg::SUM_W'(prod_reg[j]) + aapr_pkg::SUM_W'(extra_reg[j]);
            m_next[j]    = aapr_pkg::q30_clamp_shift(aapr_pkg::WIDE_W'(entry_sum[j]));
            mp_next[j]   = aapr_pkg::MP_W'(m_reg[j]) * aapr_pkg::MP_W'(p3_reg[j]);
        end
        dot = aapr_pkg::DOT_W'(mp_reg[0]) + aapr_pkg::DOT_W'(mp_reg[1])
            + aapr_pkg::DOT_W'(mp_reg[2]);
        r_next = aapr_pkg::q30_clamp_shift(aapr_pkg::WIDE_W'(dot));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            aa_reg     <= aa_next;
            sa_neg_reg <= sa_neg_next;
            sa_pos_reg <= sa_pos_next;
            omc_reg    <= omc;
            cos_reg    <= cosine;
            p1_reg     <= offset;
        end
        if (ctl.load[2])
        begin
            prod_reg  <= prod_next;
            extra_reg <= extra_next;
            p2_reg    <= p1_reg;
        end
        if (ctl.load[3])
        begin
            m_reg  <= m_next;
            p3_reg <= p2_reg;
        end
        if (ctl.load[4])
        begin
            mp_reg <= mp_next;
        end
        if (ctl.load[5])
        begin
            r_reg <= r_next;
        end
    end

    assign row_result = r_reg;

endmodule

// ===== sv/aapr_merge.sv =====
// ----------------------------------------------------------------------------
// Axis-angle point rotation: merge stage
// Re-adds the pivot to the lane results (y with the pivot sign flipped), or passes the point through.
// ----------------------------------------------------------------------------
module aapr_merge (
    input  logic                clk,
    input  aapr_pkg::pipe_ctl_t ctl,
    input  aapr_pkg::coord_t    pivot_x,
    input  aapr_pkg::coord_t    pivot_y,
    input  aapr_pkg::coord_t    pivot_z,
    input  aapr_pkg::entry_t    lane_result [aapr_pkg::NUM_AXES],
    input  aapr_pkg::coord_t    point [aapr_pkg::NUM_AXES],
    output aapr_pkg::out_t      rotated_x,
    output aapr_pkg::out_t      rotated_y,
    output aapr_pkg::out_t      rotated_z
);

    localparam int OW = aapr_pkg::OUT_W;
    localparam int LAST = aapr_pkg::STAGES - 1;

    aapr_pkg::out_t rx_reg, rx_next;
    aapr_pkg::out_t ry_reg, ry_next;
    aapr_pkg::out_t rz_reg, rz_next;

    always_comb
    begin
        if (ctl.rotate)
        begin
            rx_next = OW'(pivot_x) + OW'(lane_result[0]);
            // y runs with the pivot sign flipped
            ry_next = OW'(lane_result[1]) - OW'(pivot_y);
            rz_next = OW'(pivot_z) + OW'(lane_result[2]);
        end
        else
        begin
            rx_next = OW'(point[0]);
            ry_next = OW'(point[1]);
            rz_next = OW'(point[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[LAST])
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
        end
    end

    assign rotated_x = rx_reg;
    assign rotated_y = ry_reg;
    assign rotated_z = rz_reg;

endmodule

// ===== sv/axis_angle_point_rotation.sv =====
// ----------------------------------------------------------------------------
// Axis-angle point rotation
// Rotates a point about a pivot around a Q15 axis (Rodrigues matrix, Q30
// clamps), three row lanes in parallel and a merge stage.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    point_x/y/z, cosine_value, sine_value
//   out      source     out_valid / out_stall  rotated_x/y/z
//   cfg      sink       cfg_write              cfg_addr, cfg_data
//
// One point per clock while out_stall is low, through the seven-stage
// pipeline (capture, two multiply stages per matrix entry, clamp, offset
// multiply, dot clamp, merge register).
// Reset clears every pipeline valid bit and all configuration registers.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up; in_stall rises only when every stage is full and
// out_stall is high.
// ----------------------------------------------------------------------------
module axis_angle_point_rotation (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  aapr_pkg::coord_t                      point_x,
    input  aapr_pkg::coord_t                      point_y,
    input  aapr_pkg::coord_t                      point_z,
    input  aapr_pkg::q15_t                        cosine_value,
    input  aapr_pkg::q15_t                        sine_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output aapr_pkg::out_t                        rotated_x,
    output aapr_pkg::out_t                        rotated_y,
    output aapr_pkg::out_t                        rotated_z,
    input  logic                                  cfg_write,
    input  logic [aapr_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [aapr_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int NA = aapr_pkg::NUM_AXES;
    localparam int NS = aapr_pkg::STAGES;
    localparam int OFW = aapr_pkg::OFFSET_W;

    // configuration
    logic             rotation_enable_reg;
    aapr_pkg::q15_t   axis_reg [NA];
    aapr_pkg::coord_t pivot_x_reg, pivot_y_reg, pivot_z_reg;

    // pipeline control
    logic [NS-1:0]       vld_reg, vld_next;
    logic [NS:0]         ready;
    aapr_pkg::pipe_ctl_t pipe_ctl;

    // stage 0 capture
    aapr_pkg::q15_t    cos_reg, sin_reg;
    aapr_pkg::omc_t    omc_reg, omc_next;
    aapr_pkg::offset_t offset_reg [NA];
    aapr_pkg::offset_t offset_next [NA];
    // point delay line for pass-through, one tap per stage ahead of the merge
    aapr_pkg::coord_t  pt_reg [NS-1][NA];

    aapr_pkg::entry_t  lane_result [NA];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_enable_reg <= 1'b0;
            axis_reg[0]         <= '0;
            axis_reg[1]         <= '0;
            axis_reg[2]         <= '0;
            pivot_x_reg         <= '0;
            pivot_y_reg         <= '0;
            pivot_z_reg         <= '0;
        end
        else if (cfg_write)
        begin
            case (aapr_pkg::cfg_index_t'(cfg_addr))
                aapr_pkg::REG_ROTATION_ENABLE: rotation_enable_reg <= cfg_data[0];
                aapr_pkg::REG_AXIS_X:  axis_reg[0] <= aapr_pkg::q15_t'(cfg_data[15:0]);
                aapr_pkg::REG_AXIS_Y:  axis_reg[1] <= aapr_pkg::q15_t'(cfg_data[15:0]);
                aapr_pkg::REG_AXIS_Z:  axis_reg[2] <= aapr_pkg::q15_t'(cfg_data[15:0]);
                aapr_pkg::REG_PIVOT_X: pivot_x_reg <= aapr_pkg::coord_t'(cfg_data);
                aapr_pkg::REG_PIVOT_Y: pivot_y_reg <= aapr_pkg::coord_t'(cfg_data);
                aapr_pkg::REG_PIVOT_Z: pivot_z_reg <= aapr_pkg::coord_t'(cfg_data);
                default: ;
            endcase
        end
    end

    // A stage takes new data when it is empty or its successor moves on.
    always_comb
    begin
        ready[NS] = !out_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            ready[k] = !vld_reg[k] || ready[k+1];
        end
        vld_next[0] = ready[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            vld_next[k] = ready[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign pipe_ctl.load   = ready[NS-1:0];
    assign pipe_ctl.rotate = rotation_enable_reg;
    assign in_stall        = !ready[0];
    assign out_valid       = vld_reg[NS-1];

    always_comb
    begin
        omc_next       = aapr_pkg::Q15_ONE - aapr_pkg::OMC_W'(cosine_value);
        offset_next[0] = OFW'(point_x) - OFW'(pivot_x_reg);
        offset_next[1] = OFW'(point_y) + OFW'(pivot_y_reg);
        offset_next[2] = OFW'(point_z) - OFW'(pivot_z_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            cos_reg    <= cosine_value;
            sin_reg    <= sine_value;
            omc_reg    <= omc_next;
            offset_reg <= offset_next;
            pt_reg[0][0] <= point_x;
            pt_reg[0][1] <= point_y;
            pt_reg[0][2] <= point_z;
        end
        for (int k = 1; k < NS - 1; k++)
        begin
            if (ready[k])
            begin
                pt_reg[k] <= pt_reg[k-1];
            end
        end
    end

    for (genvar g = 0; g < NA; g++)
    begin : g_lane
        aapr_lane #(
            .ROW (g)
        ) u_lane (
            .clk        (clk),
            .ctl        (pipe_ctl),
            .axis       (axis_reg),
            .cosine     (cos_reg),
            .sine       (sin_reg),
            .omc        (omc_reg),
            .offset     (offset_reg),
            .row_result (lane_result[g])
        );
    end

    aapr_merge u_merge (
        .clk         (clk),
        .ctl         (pipe_ctl),
        .pivot_x     (pivot_x_reg),
        .pivot_y     (pivot_y_reg),
        .pivot_z     (pivot_z_reg),
        .lane_result (lane_result),
        .point       (pt_reg[NS-2]),
        .rotated_x   (rotated_x),
        .rotated_y   (rotated_y),
        .rotated_z   (rotated_z)
    );

endmodule

// ===== sv/aapr_checker.sv =====
// ----------------------------------------------------------------------------
// Axis-angle point rotation checker
// Port-level checks on the request channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "axis_angle_point_rotation_defines.svh"

module aapr_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input aapr_pkg::out_t   rotated_x,
    input aapr_pkg::out_t   rotated_y,
    input aapr_pkg::out_t   rotated_z
);

    // hold a stalled result request steady
    `AAPR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(rotated_x) && $stable(rotated_y) && $stable(rotated_z), "stalled result changed")

    // back-pressure only when the output is full and stalled
    `AAPR_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without output stall")

    // drop any result while reset is held
    `AAPR_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid && !in_stall, "activity during reset")

    // a request arriving at a flowing pipe is never refused
    `AAPR_ASSERT(a_flow, in_valid && !out_stall |-> !in_stall, "request refused while output flows")

endmodule

bind axis_angle_point_rotation aapr_checker u_aapr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .rotated_z (rotated_z)
);
